// File: hdl/frb_pkg.sv
// ----------------------------------------------------------------------------
// frb_pkg: shared types and constants of the fragment reassembly buffer
// Item and result layouts, status codes, request kinds and store sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package frb_pkg;

  // Fixed field widths
  localparam int PID_W  = 6;
  localparam int OFF_W  = 10;
  localparam int RIDX_W = 16;
  localparam int LEN_W  = 16;

  // Message store and context sizes
  localparam int          ADDR_W      = 16;
  localparam int unsigned STORE_DEPTH = 65536;
  localparam int          CNT_W       = 17;
  localparam int unsigned LEN_PREFIX  = 4;

  // Request kinds
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_PENDING  = 2'd0,
    ST_COMPLETE = 2'd1,
    ST_ERROR    = 2'd2,
    ST_READ     = 2'd3
  } status_t;

  // One input item
  typedef struct packed {
    logic              req_type;
    logic [PID_W-1:0]  packet_id;
    logic [OFF_W-1:0]  byte_index;
    logic [7:0]        data_byte;
    logic              end_of_packet;
    logic [RIDX_W-1:0] read_index;
  } item_t;

  // Store access and result fields decided for one item
  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wdata;
    status_t           status;
    logic [LEN_W-1:0]  length;
  } op_t;

endpackage

`default_nettype wire

// File: hdl/frb_ctx.sv
// ----------------------------------------------------------------------------
// frb_ctx: reassembly context and per-item decision
// Holds byte count, declared length and completion flags; decides status,
// store access and the next context for the item in the input register.
// ----------------------------------------------------------------------------
`default_nettype none

module frb_ctx #(
  parameter int PAYLOAD_BYTES = 1024,
  parameter int MAX_FRAGMENTS = 64
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           go,
  input  wire frb_pkg::item_t item,
  output frb_pkg::op_t        op
);

  localparam int unsigned SPAN = PAYLOAD_BYTES * MAX_FRAGMENTS;
  localparam int unsigned CAPACITY =
    (SPAN < frb_pkg::STORE_DEPTH) ? SPAN : frb_pkg::STORE_DEPTH;
  localparam int unsigned LEN_MAX = CAPACITY - frb_pkg::LEN_PREFIX;
  localparam int AW = $clog2((2 ** frb_pkg::PID_W) * PAYLOAD_BYTES) + 1;

  logic [frb_pkg::CNT_W-1:0] byte_count, byte_count_next;
  logic [31:0]               declared_length, declared_length_next;
  logic                      first_seen, first_seen_next;
  logic                      done_flag, done_flag_next;

  logic [frb_pkg::CNT_W-1:0] eff_count, cnt_inc, total;
  logic [31:0]               eff_len, len_upd;
  logic                      eff_first, first_upd;
  logic [AW-1:0]             addr;
  logic                      range_bad, count_full, len_bad;
  logic [frb_pkg::CNT_W-1:0] rd_sum;

  // Context as seen by a write: a finished message is dropped first
  assign eff_count = done_flag ? '0 : byte_count;
  assign eff_len   = done_flag ? '0 : declared_length;
  assign eff_first = done_flag ? 1'b0 : first_seen;

  // Store address of a written byte and its range checks
  assign addr = AW'(item.packet_id) * AW'(PAYLOAD_BYTES) + AW'(item.byte_index);
  assign range_bad = (32'(item.packet_id) >= 32'(MAX_FRAGMENTS)) ||
                     (32'(item.byte_index) >= 32'(PAYLOAD_BYTES)) ||
                     (32'(addr) >= CAPACITY);
  assign count_full = 32'(eff_count) >= CAPACITY;
  assign cnt_inc    = eff_count + 1'b1;
  assign first_upd  = eff_first | (item.packet_id == '0);

  // Replace one length lane when a prefix byte of fragment 0 is written
  always_comb begin
    len_upd = eff_len;
    if (item.packet_id == '0 && 32'(item.byte_index) < frb_pkg::LEN_PREFIX) begin
      for (int lane = 0; lane < 4; lane++) begin
        if (item.byte_index[1:0] == 2'(lane)) begin
          len_upd[lane*8 +: 8] = item.data_byte;
        end
      end
    end
  end

  assign len_bad = len_upd > LEN_MAX;
  assign total   = frb_pkg::CNT_W'(len_upd) + frb_pkg::CNT_W'(frb_pkg::LEN_PREFIX);
  assign rd_sum  = frb_pkg::CNT_W'(item.read_index) +
                   frb_pkg::CNT_W'(frb_pkg::LEN_PREFIX);

  // Decide status, store access and next context
  always_comb begin
    byte_count_next      = byte_count;
    declared_length_next = declared_length;
    first_seen_next      = first_seen;
    done_flag_next       = done_flag;
    op.wr_en  = 1'b0;
    op.rd_en  = 1'b0;
    op.addr   = addr[frb_pkg::ADDR_W-1:0];
    op.wdata  = item.data_byte;
    op.status = frb_pkg::ST_PENDING;

    if (item.req_type == frb_pkg::REQ_READ) begin
      op.addr = rd_sum[frb_pkg::ADDR_W-1:0];
      priority if (!done_flag) begin
        op.status = frb_pkg::ST_PENDING;
      end else if (32'(item.read_index) >= declared_length || rd_sum[frb_pkg::ADDR_W]) begin
        op.status = frb_pkg::ST_ERROR;
      end else begin
        op.rd_en  = 1'b1;
        op.status = frb_pkg::ST_READ;
      end
    end else begin
      byte_count_next      = eff_count;
      declared_length_next = eff_len;
      first_seen_next      = eff_first;
      done_flag_next       = 1'b0;
      if (range_bad || count_full) begin
        op.status            = frb_pkg::ST_ERROR;
        byte_count_next      = '0;
        declared_length_next = '0;
        first_seen_next      = 1'b0;
      end else begin
        op.wr_en             = 1'b1;
        byte_count_next      = cnt_inc;
        declared_length_next = len_upd;
        if (item.end_of_packet) begin
          first_seen_next = first_upd;
          priority if (!first_upd) begin
            op.status = frb_pkg::ST_PENDING;
          end else if (len_bad || cnt_inc > total) begin
            op.status            = frb_pkg::ST_ERROR;
            byte_count_next      = '0;
            declared_length_next = '0;
            first_seen_next      = 1'b0;
          end else if (cnt_inc < total) begin
            op.status = frb_pkg::ST_PENDING;
          end else begin
            op.status      = frb_pkg::ST_COMPLETE;
            done_flag_next = 1'b1;
          end
        end
      end
    end

    // Length is shown from the context left behind by this item
    if (first_seen_next && declared_length_next <= LEN_MAX) begin
      op.length = declared_length_next[frb_pkg::LEN_W-1:0];
    end else begin
      op.length = '0;
    end
  end

  // Advance the context when the item is processed
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count      <= '0;
      declared_length <= '0;
      first_seen      <= 1'b0;
      done_flag       <= 1'b0;
    end else if (go) begin
      byte_count      <= byte_count_next;
      declared_length <= declared_length_next;
      first_seen      <= first_seen_next;
      done_flag       <= done_flag_next;
    end
  end

`ifndef SYNTH
  a_done_needs_first: assert property (@(posedge clk) disable iff (rst)
    done_flag |-> first_seen)
    else $error("message complete without fragment 0");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(byte_count) <= CAPACITY)
    else $error("byte count beyond capacity");

  a_done_count: assert property (@(posedge clk) disable iff (rst)
    done_flag |-> (32'(byte_count) == declared_length + frb_pkg::LEN_PREFIX))
    else $error("complete message with mismatched byte count");
`endif

endmodule

`default_nettype wire

// File: hdl/fragment_reassembly_buffer.sv
// ----------------------------------------------------------------------------
// fragment_reassembly_buffer: message rebuild from out-of-order fragments
// Input register, context logic, message store and result register.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries requests: tuser selects write (payload byte) or read
//   (message byte), tlast marks the last byte of a fragment. Every request
//   yields exactly one result on the master stream: tuser holds the status
//   (pending, complete, error, read data), tdata the declared message length
//   and the read byte.
//   A request passes through the input register, then the context decision
//   and the store access, whose registered read data lands with the result
//   register.
//   Throughput is one request per cycle while results are taken; the context
//   logic is combinational and the single store port does one access per cycle.
//   Reset clears the context (count, length, flags) and the valid flags of
//   both pipeline registers; store contents stay undefined until written.
//   When the receiver stalls, the result holds, one more request waits in the
//   input register, and s_axis_tready then drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module fragment_reassembly_buffer #(
  parameter int PAYLOAD_BYTES = 1024,
  parameter int MAX_FRAGMENTS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // packet_id[5:0], byte_index[15:6], data_byte[23:16], read_index[39:24]
  input  wire logic [39:0] s_axis_tdata,
  // req_type[0]
  input  wire logic        s_axis_tuser,
  // end_of_packet
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // message_length[15:0], read_data[23:16]
  output logic [23:0]      m_axis_tdata,
  // status[1:0]
  output logic [1:0]       m_axis_tuser
);

  frb_pkg::item_t                s1_item;
  logic                          s1_valid;
  logic                          s2_valid;
  frb_pkg::status_t              s2_status;
  logic [frb_pkg::LEN_W-1:0]     s2_length;
  logic [7:0]                    rdata;
  logic                          s2_free, go;
  frb_pkg::op_t                  op;
  logic [7:0]                    store [0:frb_pkg::STORE_DEPTH-1];

  // Pipeline handshake
  assign s2_free       = !s2_valid || m_axis_tready;
  assign go            = s1_valid && s2_free;
  assign s_axis_tready = !s1_valid || go;

  // Capture the input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_item.req_type      <= s_axis_tuser;
      s1_item.packet_id     <= s_axis_tdata[5:0];
      s1_item.byte_index    <= s_axis_tdata[15:6];
      s1_item.data_byte     <= s_axis_tdata[23:16];
      s1_item.end_of_packet <= s_axis_tlast;
      s1_item.read_index    <= s_axis_tdata[39:24];
    end
  end

  frb_ctx #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES),
    .MAX_FRAGMENTS (MAX_FRAGMENTS)
  ) u_ctx (
    .clk  (clk),
    .rst  (rst),
    .go   (go),
    .item (s1_item),
    .op   (op)
  );

  // Message store: one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (go && op.wr_en) begin
      store[op.addr] <= op.wdata;
    end
    if (go && op.rd_en) begin
      rdata <= store[op.addr];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= go;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      s2_status <= op.status;
      s2_length <= op.length;
    end
  end

  assign m_axis_tvalid = s2_valid;
  assign m_axis_tuser  = s2_status;
  assign m_axis_tdata  = {(s2_status == frb_pkg::ST_READ) ? rdata : 8'h00, s2_length};

`ifndef SYNTH
  a_rdata_only_on_read: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser != frb_pkg::ST_READ) |-> (m_axis_tdata[23:16] == 8'h00))
    else $error("read byte shown on a non-read result");

  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !go) |=> s1_valid)
    else $error("input register lost a waiting request");

  a_ready_low_only_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (s1_valid && s2_valid && !m_axis_tready))
    else $error("input stalled while the pipeline can move");
`endif

endmodule

`default_nettype wire

// File: tb/fragment_reassembly_buffer_tb.sv
// ----------------------------------------------------------------------------
// fragment_reassembly_buffer_tb: self-checking bench for message reassembly
// Drives write and read requests on the input stream and checks every result
// against a cycle-free model of the context and the message store. A short
// table of corner cases comes first, then one message that seeds the low store
// entries, then random messages with random fragment order, flaws and noise
// under several idle and stall patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fragment_reassembly_buffer_tb;

  localparam int PAYLOAD_BYTES = 1024;
  localparam int MAX_FRAGMENTS = 64;
  localparam int unsigned SPAN = PAYLOAD_BYTES * MAX_FRAGMENTS;
  localparam int unsigned CAP =
    (SPAN < frb_pkg::STORE_DEPTH) ? SPAN : frb_pkg::STORE_DEPTH;
  // Seed message covers every store entry a message read can reach
  localparam int unsigned SEED_TOTAL = 516;
  localparam int PHASE_ITEMS = 210;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 5000;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    frb_pkg::status_t status;
    logic [15:0]      length;
    logic [7:0]       rdata;
  } result_t;

  typedef struct {
    frb_pkg::item_t it;
    bit             typed;
    result_t        want;
  } stim_row_t;

  typedef enum int {MSG_CLEAN, MSG_SHORT, MSG_EXTRA} msg_flaw_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // packet_id[5:0], byte_index[15:6], data_byte[23:16], read_index[39:24]
  logic [39:0] s_axis_tdata = '0;
  // req_type[0]
  logic        s_axis_tuser = 1'b0;
  // end_of_packet
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // message_length[15:0], read_data[23:16]
  logic [23:0] m_axis_tdata;
  // status[1:0]
  logic [1:0]  m_axis_tuser;

  // Model of the reassembly context and store
  logic [7:0]  store_image [0:frb_pkg::STORE_DEPTH-1];
  int unsigned ctx_bytes;
  logic [31:0] ctx_len;
  bit          frag0_ended;
  bit          msg_complete;

  result_t     pending_results [$];
  stim_row_t   corner_rows [$];
  int          mismatches = 0;
  int          items_sent = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_req = 1'b0;
  int          hold_cnt = 0;
  int          quiet_cycles = 0;

  fragment_reassembly_buffer #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES),
    .MAX_FRAGMENTS(MAX_FRAGMENTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void drop_context();
    ctx_bytes = 0;
    ctx_len = '0;
    frag0_ended = 1'b0;
    msg_complete = 1'b0;
  endfunction

  function automatic logic [15:0] shown_length();
    if (!frag0_ended || ctx_len > CAP - frb_pkg::LEN_PREFIX) return '0;
    return ctx_len[15:0];
  endfunction

  // Advance the context by one request and return the result it yields
  function automatic result_t reassemble_step(frb_pkg::item_t it);
    result_t     r;
    int unsigned pid;
    int unsigned off;
    int unsigned addr;
    bit          bad;
    r = '0;
    r.status = frb_pkg::ST_PENDING;
    bad = 1'b0;
    if (it.req_type == frb_pkg::REQ_READ) begin
      if (!msg_complete) begin
        r.status = frb_pkg::ST_PENDING;
      end else if (32'(it.read_index) >= ctx_len) begin
        r.status = frb_pkg::ST_ERROR;
      end else if (32'(it.read_index) + frb_pkg::LEN_PREFIX >= frb_pkg::STORE_DEPTH) begin
        r.status = frb_pkg::ST_ERROR;
      end else begin
        r.status = frb_pkg::ST_READ;
        r.rdata = store_image[16'(32'(it.read_index) + frb_pkg::LEN_PREFIX)];
      end
      r.length = shown_length();
      return r;
    end
    if (msg_complete) drop_context();
    pid = 32'(it.packet_id);
    off = 32'(it.byte_index);
    addr = pid * PAYLOAD_BYTES + off;
    if (pid >= MAX_FRAGMENTS || off >= PAYLOAD_BYTES || addr >= frb_pkg::STORE_DEPTH ||
        addr >= CAP || ctx_bytes >= CAP) begin
      bad = 1'b1;
    end else begin
      store_image[16'(addr)] = it.data_byte;
      ctx_bytes++;
      if (pid == 0 && off < frb_pkg::LEN_PREFIX) ctx_len[8*off +: 8] = it.data_byte;
      if (it.end_of_packet) begin
        if (pid == 0) frag0_ended = 1'b1;
        if (frag0_ended) begin
          if (ctx_len > CAP - frb_pkg::LEN_PREFIX) begin
            bad = 1'b1;
          end else if (ctx_bytes > ctx_len + frb_pkg::LEN_PREFIX) begin
            bad = 1'b1;
          end else if (ctx_bytes == ctx_len + frb_pkg::LEN_PREFIX) begin
            msg_complete = 1'b1;
            r.status = frb_pkg::ST_COMPLETE;
          end
        end
      end
    end
    if (bad) begin
      drop_context();
      r.status = frb_pkg::ST_ERROR;
    end
    r.length = shown_length();
    return r;
  endfunction

  function automatic frb_pkg::item_t make_write(int unsigned pid, int unsigned off,
                                                int unsigned data, bit eop);
    frb_pkg::item_t it;
    it = '0;
    it.req_type = frb_pkg::REQ_WRITE;
    it.packet_id = 6'(pid);
    it.byte_index = 10'(off);
    it.data_byte = 8'(data);
    it.end_of_packet = eop;
    return it;
  endfunction

  function automatic frb_pkg::item_t make_read(int unsigned ridx);
    frb_pkg::item_t it;
    it = '0;
    it.req_type = frb_pkg::REQ_READ;
    it.read_index = 16'(ridx);
    return it;
  endfunction

  function automatic void corner(frb_pkg::item_t it, bit typed, frb_pkg::status_t st,
                                 int unsigned len, int unsigned rd);
    stim_row_t row;
    row.it = it;
    row.typed = typed;
    row.want.status = st;
    row.want.length = 16'(len);
    row.want.rdata = 8'(rd);
    corner_rows.insert(corner_rows.size(), row);
  endfunction

  // Present one request and hold it until the block takes it
  task automatic offer(frb_pkg::item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {it.read_index, it.data_byte, it.byte_index, it.packet_id};
    s_axis_tuser <= it.req_type;
    s_axis_tlast <= it.end_of_packet;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic submit(frb_pkg::item_t it);
    offer(it);
    pending_results.insert(pending_results.size(), reassemble_step(it));
  endtask

  task automatic send_noise();
    frb_pkg::item_t it;
    it.req_type = 1'($urandom_range(1));
    it.packet_id = 6'($urandom_range(63));
    it.byte_index = 10'($urandom_range(1023));
    it.data_byte = 8'($urandom_range(255));
    it.end_of_packet = 1'($urandom_range(1));
    it.read_index = 16'($urandom_range(65531));
    // keep noise writes off the length prefix
    if (it.req_type == frb_pkg::REQ_WRITE && it.packet_id == '0 &&
        it.byte_index < 10'(frb_pkg::LEN_PREFIX)) begin
      it.byte_index = it.byte_index + 10'(frb_pkg::LEN_PREFIX);
    end
    submit(it);
  endtask

  // Send one message split into fragments in random order, then issue up to three reads
  task automatic send_message();
    int unsigned body_len;
    int unsigned total;
    int unsigned nfrag;
    int unsigned rem;
    int unsigned lo0;
    int unsigned pick;
    int unsigned tmp;
    int unsigned nread;
    int unsigned ridx;
    int unsigned off;
    int unsigned data;
    int unsigned bad_frag;
    int unsigned bad_pos;
    int unsigned pid [4];
    int unsigned base [4];
    int unsigned size [4];
    int unsigned order [4];
    bit          clash;
    msg_flaw_t   flaw;
    body_len = ($urandom_range(99) < 90) ? $urandom_range(40) : $urandom_range(41, 300);
    total = body_len + frb_pkg::LEN_PREFIX;
    nfrag = $urandom_range(1, 4);
    lo0 = (body_len < 256) ? 1 : 2;
    pick = $urandom_range(99);
    flaw = (pick < 80) ? MSG_CLEAN : (pick < 90) ? MSG_SHORT : MSG_EXTRA;
    // split the bytes over the fragments, fragment 0 first
    size[0] = $urandom_range(lo0, total - (nfrag - 1));
    rem = total - size[0];
    for (int k = 1; k < nfrag; k++) begin
      size[k] = (k == nfrag - 1) ? rem : $urandom_range(1, rem - (nfrag - 1 - k));
      rem -= size[k];
    end
    pid[0] = 0;
    base[0] = 0;
    for (int k = 1; k < nfrag; k++) begin
      do begin
        pid[k] = $urandom_range(1, 63);
        clash = 1'b0;
        for (int j = 1; j < k; j++) if (pid[j] == pid[k]) clash = 1'b1;
      end while (clash);
      base[k] = $urandom_range(PAYLOAD_BYTES - size[k]);
    end
    for (int k = 0; k < nfrag; k++) order[k] = k;
    for (int k = nfrag - 1; k > 0; k--) begin
      pick = $urandom_range(k);
      tmp = order[k];
      order[k] = order[pick];
      order[pick] = tmp;
    end
    bad_frag = $urandom_range(nfrag - 1);
    bad_pos = $urandom_range(size[bad_frag] - 1);
    for (int n = 0; n < nfrag; n++) begin
      for (int j = 0; j < size[order[n]]; j++) begin
        off = base[order[n]] + j;
        data = (pid[order[n]] == 0 && off < frb_pkg::LEN_PREFIX)
               ? (body_len >> (8 * off)) & 8'hFF : $urandom_range(255);
        if (order[n] == bad_frag && j == bad_pos) begin
          if (flaw == MSG_SHORT) continue;
          if (flaw == MSG_EXTRA) submit(make_write(pid[order[n]], off, data, 1'b0));
        end
        submit(make_write(pid[order[n]], off, data, j == size[order[n]] - 1));
      end
      if ($urandom_range(9) == 0) submit(make_read($urandom_range(65531)));
    end
    nread = $urandom_range(3);
    for (int k = 0; k < nread; k++) begin
      if (body_len > 0 && $urandom_range(9) < 8) ridx = $urandom_range(body_len - 1);
      else ridx = $urandom_range(body_len, 65531);
      submit(make_read(ridx));
    end
  endtask

  // Fill the low store entries as one complete message, then read its ends and one index past them
  task automatic seed_store();
    int unsigned data;
    for (int off = 0; off < SEED_TOTAL; off++) begin
      data = (off < frb_pkg::LEN_PREFIX)
             ? ((SEED_TOTAL - frb_pkg::LEN_PREFIX) >> (8 * off)) & 8'hFF
             : $urandom_range(255);
      submit(make_write(0, off, data, off == SEED_TOTAL - 1));
    end
    submit(make_read(0));
    submit(make_read(SEED_TOTAL - frb_pkg::LEN_PREFIX - 1));
    submit(make_read(SEED_TOTAL - frb_pkg::LEN_PREFIX));
  endtask

  task automatic run_phase(int send_pct, int recv_pct, bit squeeze);
    int target;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    if (squeeze) hold_req = 1'b1;
    target = items_sent + PHASE_ITEMS;
    while (items_sent < target) begin
      if ($urandom_range(99) < 10) send_noise();
      else send_message();
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_cnt = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.status = frb_pkg::status_t'(m_axis_tuser);
      got.length = m_axis_tdata[15:0];
      got.rdata = m_axis_tdata[23:16];
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("ERROR %0t: unexpected result status %0d length %0d data %02h",
                   $time, got.status, got.length, got.rdata);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.length !== want.length ||
            got.rdata !== want.rdata) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("ERROR %0t: status %0d/%0d length %0d/%0d data %02h/%02h (exp/got)",
                     $time, want.status, got.status, want.length, got.length,
                     want.rdata, got.rdata);
        end
      end
    end
  end

  // End the run when no transfer happens for too long
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("fragment_reassembly_buffer: mismatch");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t row;
    result_t   pred;
    drop_context();

    // corner cases: request, typed?, expected status, length, read data
    corner(make_read(0),                      1'b1, frb_pkg::ST_PENDING,  0, 8'h00);
    corner(make_write(63, 1023, 8'hFF, 1'b1), 1'b1, frb_pkg::ST_PENDING,  0, 8'h00);
    corner(make_write(0, 0, 8'h00, 1'b0),     1'b0, frb_pkg::ST_PENDING,  0, 8'h00);
    corner(make_write(0, 1, 8'h00, 1'b0),     1'b0, frb_pkg::ST_PENDING,  0, 8'h00);
    corner(make_write(0, 2, 8'h00, 1'b0),     1'b0, frb_pkg::ST_PENDING,  0, 8'h00);
    corner(make_write(0, 3, 8'h00, 1'b1),     1'b1, frb_pkg::ST_ERROR,    0, 8'h00);
    corner(make_write(0, 0, 8'hFD, 1'b0),     1'b0, frb_pkg::ST_PENDING,  0, 8'h00);
    corner(make_write(0, 1, 8'hFF, 1'b1),     1'b1, frb_pkg::ST_ERROR,    0, 8'h00);
    corner(make_write(0, 0, 8'h00, 1'b0),     1'b0, frb_pkg::ST_PENDING,  0, 8'h00);
    corner(make_write(0, 1, 8'h00, 1'b0),     1'b0, frb_pkg::ST_PENDING,  0, 8'h00);
    corner(make_write(0, 2, 8'h00, 1'b0),     1'b0, frb_pkg::ST_PENDING,  0, 8'h00);
    corner(make_write(0, 3, 8'h00, 1'b1),     1'b1, frb_pkg::ST_COMPLETE, 0, 8'h00);
    corner(make_read(0),                      1'b1, frb_pkg::ST_ERROR,    0, 8'h00);
    corner(make_write(0, 0, 8'h02, 1'b0),     1'b1, frb_pkg::ST_PENDING,  0, 8'h00);
    corner(make_write(0, 1, 8'h00, 1'b0),     1'b0, frb_pkg::ST_PENDING,  0, 8'h00);
    corner(make_write(0, 2, 8'h00, 1'b0),     1'b0, frb_pkg::ST_PENDING,  0, 8'h00);
    corner(make_write(0, 3, 8'h00, 1'b0),     1'b0, frb_pkg::ST_PENDING,  0, 8'h00);
    corner(make_write(0, 4, 8'h5A, 1'b1),     1'b1, frb_pkg::ST_PENDING,  2, 8'h00);
    corner(make_read(0),                      1'b1, frb_pkg::ST_PENDING,  2, 8'h00);
    corner(make_write(0, 5, 8'hC3, 1'b1),     1'b1, frb_pkg::ST_COMPLETE, 2, 8'h00);
    corner(make_read(1),                      1'b1, frb_pkg::ST_READ,     2, 8'hC3);
    corner(make_read(0),                      1'b1, frb_pkg::ST_READ,     2, 8'h5A);
    corner(make_read(2),                      1'b1, frb_pkg::ST_ERROR,    2, 8'h00);
    corner(make_read(65531),                  1'b1, frb_pkg::ST_ERROR,    2, 8'h00);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // walk the corner table
    foreach (corner_rows[i]) begin
      row = corner_rows[i];
      offer(row.it);
      pred = reassemble_step(row.it);
      pending_results.insert(pending_results.size(), row.typed ? row.want : pred);
    end

    seed_store();

    // random messages under different idle and stall patterns
    run_phase(0, 0, 1'b0);
    run_phase(87, 0, 1'b0);
    run_phase(0, 87, 1'b0);
    run_phase(6, 6, 1'b0);
    run_phase(0, 0, 1'b1);

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("fragment_reassembly_buffer: match");
    end else begin
      $display("fragment_reassembly_buffer: mismatch");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/frb_pkg.sv
hdl/frb_ctx.sv
hdl/fragment_reassembly_buffer.sv
tb/fragment_reassembly_buffer_tb.sv
